>>> hdl/ptjp_pkg.sv
// Shared types, codes, reset values and helper functions of the PIN table block.
package ptjp_pkg;

    localparam int TABLE_SLOTS_DEF  = 16;
    localparam int RING_PAGES_DEF   = 8;
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 1024;

    localparam logic [63:0] DEFAULT_ADMIN_KEY_RESET = 64'h3837_3635_3433_3231;
    localparam logic [31:0] REGION_BASE_RESET       = 32'h0003_F800;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_ADMIN_KEY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_BASE       = 2'd1;

    localparam logic [2:0] ACT_VERIFY_ADMIN = 3'd0;
    localparam logic [2:0] ACT_VERIFY_USER  = 3'd1;
    localparam logic [2:0] ACT_STORE        = 3'd2;
    localparam logic [2:0] ACT_INIT         = 3'd3;
    localparam logic [2:0] ACT_RESTORE      = 3'd4;

    localparam int SUM_W = 17;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        too_long;
    } norm_t;

    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] word;
    } entry_t;

    typedef struct packed {
        logic        matched;
        logic        status;
        logic        write_page;
        logic [31:0] page_sequence;
        logic [2:0]  page_slot;
        logic [31:0] page_address;
        logic        erase_sector;
        logic [31:0] page_checksum;
    } result_t;

    // Keeps the characters below the length up to the first zero byte.
    function automatic norm_t pin_norm(input logic [63:0] bytes, input logic [3:0] len);
        norm_t      r;
        logic       run;
        logic [3:0] n;
        r.word = '0;
        n      = '0;
        run    = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (run && (4'(i) < len) && (bytes[8*i +: 8] != 8'h00)) begin
                r.word[8*i +: 8] = bytes[8*i +: 8];
                n = n + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        r.count    = n;
        r.too_long = (n == 4'd8) && (len > 4'd8);
        return r;
    endfunction

    function automatic logic [10:0] pin_bytesum(input logic [63:0] w);
        logic [10:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 11'(w[8*i +: 8]);
        end
        return s;
    endfunction

endpackage

>>> hdl/pin_table_with_journal_pages.sv
// PIN code table in a synchronous memory with journal page reporting.
//
//  Channel  Direction  Ports                                      Handshake
//  s_       in         s_action s_user_slot s_key_bytes ...       s_valid / s_ready
//  m_       out        m_matched m_status m_write_page m_page_*   m_valid / m_ready
//  cfg_     in         cfg_index cfg_data                         cfg_valid / cfg_ready
//
// One transaction is worked at a time. User verify walks the table memory's single read port
// one slot per cycle. Restore reduces the loaded sequence modulo RING_PAGES by a reciprocal
// multiplication in two 16-bit halves.
// After reset the table reads as empty at once; no clearing pass is needed.
// A finished result waits in the output register while the next transaction is taken.
module pin_table_with_journal_pages
    import ptjp_pkg::*;
#(
    parameter int TABLE_SLOTS  = TABLE_SLOTS_DEF,
    parameter int RING_PAGES   = RING_PAGES_DEF,
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_action,
    input  logic [7:0]             s_user_slot,
    input  logic [63:0]            s_key_bytes,
    input  logic [3:0]             s_key_length,
    input  logic [31:0]            s_restore_sequence,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_matched,
    output logic                   m_status,
    output logic                   m_write_page,
    output logic [31:0]            m_page_sequence,
    output logic [2:0]             m_page_slot,
    output logic [31:0]            m_page_address,
    output logic                   m_erase_sector,
    output logic [31:0]            m_page_checksum,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int RING_W = $clog2(RING_PAGES);

    localparam logic [63:0] RECIP_NUM  = 64'd1 << (32 + RING_W);
    localparam logic [63:0] RECIP_FULL = (RECIP_NUM + 64'(RING_PAGES) - 64'd1) / 64'(RING_PAGES);
    localparam logic [32:0] RECIP      = RECIP_FULL[32:0];

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_ADMIN     = 9'b000000010,
        S_SCAN      = 9'b000000100,
        S_SCAN_LAST = 9'b000001000,
        S_PUT       = 9'b000010000,
        S_INIT      = 9'b000100000,
        S_PAGE      = 9'b001000000,
        S_MOD       = 9'b010000000,
        S_EMIT      = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;
    logic [TABLE_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [31:0]            seq_reg, seq_next;
    logic [RING_W-1:0]      ring_reg, ring_next;
    logic [63:0]            admin_key_reg, admin_key_next;
    logic [31:0]            region_base_reg, region_base_next;

    logic [2:0]             act_reg, act_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [63:0]            word_reg, word_next;
    logic [3:0]             count_reg, count_next;
    logic                   too_long_reg, too_long_next;
    logic [31:0]            rseq_reg, rseq_next;
    logic [SLOT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                   hit_reg, hit_next;
    logic [1:0]             mod_cnt_reg, mod_cnt_next;
    logic [64:0]            prod_reg, prod_next;
    result_t                res_reg, res_next;
    result_t                out_reg, out_next;

    entry_t                 code_mem [TABLE_SLOTS];
    entry_t                 rd_data_reg;
    logic                   rd_vld_reg;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_waddr;
    entry_t                 mem_wdata;
    logic [SLOT_W-1:0]      mem_raddr;

    logic [RING_PAGES-1:0]  erase_lut;

    for (genvar g = 0; g < RING_PAGES; g++) begin : g_erase
        localparam logic ERASE_G = (((g * PAGE_BYTES) % SECTOR_BYTES) == 0);
        assign erase_lut[g] = ERASE_G;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            code_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= code_mem[mem_raddr];
        rd_vld_reg  <= slot_valid_reg[mem_raddr];
    end

    entry_t            old_entry;
    norm_t             in_norm;
    norm_t             dflt_norm;
    logic              in_range;
    logic              entry_hit;
    logic [31:0]       seq_inc;
    logic [RING_W-1:0] ring_inc;
    logic [15:0]       mul_half;
    logic [48:0]       mul_prod;

    always_comb begin
        old_entry  = rd_vld_reg ? rd_data_reg : '0;
        in_norm    = pin_norm(s_key_bytes, s_key_length);
        dflt_norm  = pin_norm(admin_key_reg, 4'd8);
        in_range   = s_user_slot < 8'(TABLE_SLOTS);
        entry_hit  = rd_vld_reg && (rd_data_reg.len >= 4'd4) && (rd_data_reg.word == word_reg);
        seq_inc    = seq_reg + 32'd1;
        ring_inc   = (seq_inc == 32'd0 || ring_reg == RING_W'(RING_PAGES - 1)) ?
                     '0 : ring_reg + RING_W'(1);
        mul_half   = (mod_cnt_reg == 2'd0) ? rseq_reg[15:0] : rseq_reg[31:16];
        mul_prod   = 49'(mul_half) * 49'(RECIP);
    end

    always_comb begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        slot_valid_next  = slot_valid_reg;
        sum_next         = sum_reg;
        seq_next         = seq_reg;
        ring_next        = ring_reg;
        admin_key_next   = admin_key_reg;
        region_base_next = region_base_reg;
        act_next         = act_reg;
        slot_next        = slot_reg;
        word_next        = word_reg;
        count_next       = count_reg;
        too_long_next    = too_long_reg;
        rseq_next        = rseq_reg;
        scan_idx_next    = scan_idx_reg;
        hit_next         = hit_reg;
        mod_cnt_next     = mod_cnt_reg;
        prod_next        = prod_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        mem_we           = 1'b0;
        mem_waddr        = slot_reg;
        mem_wdata        = '{len: count_reg, word: word_reg};
        mem_raddr        = scan_idx_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DEFAULT_ADMIN_KEY: admin_key_next   = cfg_data;
                CFG_REGION_BASE:       region_base_next = cfg_data[31:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_action == ACT_VERIFY_ADMIN || s_action == ACT_VERIFY_USER) begin
                    mem_raddr = '0;
                end else begin
                    mem_raddr = s_user_slot[SLOT_W-1:0];
                end
                if (s_valid) begin
                    act_next      = s_action;
                    slot_next     = s_user_slot[SLOT_W-1:0];
                    word_next     = in_norm.word;
                    count_next    = in_norm.count;
                    too_long_next = in_norm.too_long;
                    rseq_next     = s_restore_sequence;
                    scan_idx_next = SLOT_W'(1);
                    hit_next      = 1'b0;
                    res_next      = '0;
                    unique case (s_action) inside
                        ACT_VERIFY_ADMIN: state_next = S_ADMIN;
                        ACT_VERIFY_USER:  state_next = (TABLE_SLOTS > 1) ? S_SCAN : S_SCAN_LAST;
                        ACT_INIT:         state_next = S_INIT;
                        ACT_STORE, ACT_RESTORE: begin
                            if (in_range) begin
                                state_next = S_PUT;
                            end else begin
                                res_next.status = 1'b1;
                                state_next      = S_EMIT;
                            end
                        end
                        default:          state_next = S_EMIT;
                    endcase
                end
            end
            S_ADMIN: begin
                res_next.matched = !too_long_reg && (old_entry.word == word_reg);
                state_next       = S_EMIT;
            end
            S_SCAN: begin
                hit_next = hit_reg || entry_hit;
                if (scan_idx_reg == SLOT_W'(TABLE_SLOTS - 1)) begin
                    state_next = S_SCAN_LAST;
                end else begin
                    scan_idx_next = scan_idx_reg + SLOT_W'(1);
                end
            end
            S_SCAN_LAST: begin
                res_next.matched = !too_long_reg && (hit_reg || entry_hit);
                state_next       = S_EMIT;
            end
            S_PUT: begin
                mem_we                    = 1'b1;
                slot_valid_next[slot_reg] = 1'b1;
                sum_next = sum_reg - SUM_W'(pin_bytesum(old_entry.word))
                                   + SUM_W'(pin_bytesum(word_reg));
                if (act_reg == ACT_RESTORE) begin
                    seq_next     = rseq_reg;
                    ring_next    = '0;
                    mod_cnt_next = 2'd0;
                    state_next   = S_MOD;
                end else begin
                    state_next   = S_PAGE;
                end
            end
            S_INIT: begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata       = '{len: dflt_norm.count, word: dflt_norm.word};
                slot_valid_next = TABLE_SLOTS'(1);
                sum_next        = SUM_W'(pin_bytesum(dflt_norm.word));
                seq_next        = '0;
                ring_next       = '0;
                state_next      = S_PAGE;
            end
            S_PAGE: begin
                seq_next               = seq_inc;
                ring_next              = ring_inc;
                res_next.write_page    = 1'b1;
                res_next.page_sequence = seq_inc;
                res_next.page_slot     = 3'(ring_inc);
                res_next.page_address  = region_base_reg + 32'(ring_inc) * 32'(PAGE_BYTES);
                res_next.erase_sector  = erase_lut[ring_inc];
                res_next.page_checksum = seq_inc + 32'(sum_reg);
                state_next             = S_EMIT;
            end
            S_MOD: begin
                mod_cnt_next = mod_cnt_reg + 2'd1;
                if (mod_cnt_reg == 2'd0) begin
                    prod_next = 65'(mul_prod);
                end else if (mod_cnt_reg == 2'd1) begin
                    prod_next = prod_reg + {mul_prod, 16'd0};
                end else begin
                    ring_next  = rseq_reg[RING_W-1:0]
                               - RING_W'(prod_reg[32+RING_W +: RING_W] * RING_W'(RING_PAGES));
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            slot_valid_reg  <= '0;
            sum_reg         <= '0;
            seq_reg         <= '0;
            ring_reg        <= '0;
            admin_key_reg   <= DEFAULT_ADMIN_KEY_RESET;
            region_base_reg <= REGION_BASE_RESET;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            slot_valid_reg  <= slot_valid_next;
            sum_reg         <= sum_next;
            seq_reg         <= seq_next;
            ring_reg        <= ring_next;
            admin_key_reg   <= admin_key_next;
            region_base_reg <= region_base_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        slot_reg     <= slot_next;
        word_reg     <= word_next;
        count_reg    <= count_next;
        too_long_reg <= too_long_next;
        rseq_reg     <= rseq_next;
        scan_idx_reg <= scan_idx_next;
        hit_reg      <= hit_next;
        mod_cnt_reg  <= mod_cnt_next;
        prod_reg     <= prod_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign s_ready         = (state_reg == S_IDLE);
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_matched       = out_reg.matched;
    assign m_status        = out_reg.status;
    assign m_write_page    = out_reg.write_page;
    assign m_page_sequence = out_reg.page_sequence;
    assign m_page_slot     = out_reg.page_slot;
    assign m_page_address  = out_reg.page_address;
    assign m_erase_sector  = out_reg.erase_sector;
    assign m_page_checksum = out_reg.page_checksum;

endmodule

>>> test/pin_table_with_journal_pages_tb.sv
// Self-checking testbench for the PIN code table with journal page reporting.
module pin_table_with_journal_pages_tb;
    import ptjp_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [63:0] chars;
        logic [3:0]  count;
        logic        overlong;
    } pin_code_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [2:0]             s_action = '0;
    logic [7:0]             s_user_slot = '0;
    logic [63:0]            s_key_bytes = '0;
    logic [3:0]             s_key_length = '0;
    logic [31:0]            s_restore_sequence = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_matched;
    logic                   m_status;
    logic                   m_write_page;
    logic [31:0]            m_page_sequence;
    logic [2:0]             m_page_slot;
    logic [31:0]            m_page_address;
    logic                   m_erase_sector;
    logic [31:0]            m_page_checksum;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [63:0]            cfg_data = '0;

    logic [63:0] pin_codes [TABLE_SLOTS_DEF];
    logic [3:0]  pin_lens [TABLE_SLOTS_DEF];
    logic [16:0] table_sum = '0;
    logic [31:0] journal_seq = '0;
    logic [63:0] admin_default = DEFAULT_ADMIN_KEY_RESET;
    logic [31:0] flash_base = REGION_BASE_RESET;

    result_t replies_due [$];
    int      mismatch_count = 0;
    bit      gaps_on = 1'b1;
    int      hold_request = 0;
    int      hold_left = 0;

    pin_table_with_journal_pages u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_user_slot        (s_user_slot),
        .s_key_bytes        (s_key_bytes),
        .s_key_length       (s_key_length),
        .s_restore_sequence (s_restore_sequence),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_status           (m_status),
        .m_write_page       (m_write_page),
        .m_page_sequence    (m_page_sequence),
        .m_page_slot        (m_page_slot),
        .m_page_address     (m_page_address),
        .m_erase_sector     (m_erase_sector),
        .m_page_checksum    (m_page_checksum),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] pack_chars(input string s);
        logic [63:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++) begin
            w[8*i +: 8] = s[i];
        end
        return w;
    endfunction

    function automatic pin_code_t trim_code(input logic [63:0] bytes, input logic [3:0] len);
        pin_code_t c;
        bit        stopped;
        c = '0;
        stopped = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!stopped && i < len && bytes[8*i +: 8] != 8'h00) begin
                c.chars[8*i +: 8] = bytes[8*i +: 8];
                c.count = c.count + 4'd1;
            end else begin
                stopped = 1'b1;
            end
        end
        c.overlong = (c.count == 4'd8) && (len > 4'd8);
        return c;
    endfunction

    function automatic logic [16:0] byte_total_of(input logic [63:0] w);
        logic [16:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 17'(w[8*i +: 8]);
        end
        return s;
    endfunction

    function automatic void clear_table();
        foreach (pin_codes[i]) begin
            pin_codes[i] = '0;
            pin_lens[i] = '0;
        end
        table_sum = '0;
    endfunction

    function automatic void put_code(input int slot, input pin_code_t c);
        table_sum = table_sum - byte_total_of(pin_codes[slot]) + byte_total_of(c.chars);
        pin_codes[slot] = c.chars;
        pin_lens[slot] = c.count;
    endfunction

    function automatic result_t journal_page();
        result_t     r;
        logic [31:0] offset;
        r = '0;
        journal_seq = journal_seq + 32'd1;
        offset = 32'(journal_seq % RING_PAGES_DEF) * 32'(PAGE_BYTES_DEF);
        r.write_page = 1'b1;
        r.page_sequence = journal_seq;
        r.page_slot = 3'(journal_seq % RING_PAGES_DEF);
        r.page_address = flash_base + offset;
        r.erase_sector = (offset % SECTOR_BYTES_DEF) == 0;
        r.page_checksum = journal_seq + 32'(table_sum);
        return r;
    endfunction

    function automatic result_t apply_pin_action(input logic [2:0] act, input logic [7:0] slot,
                                                 input logic [63:0] bytes, input logic [3:0] len,
                                                 input logic [31:0] rseq);
        result_t   r;
        pin_code_t c;
        r = '0;
        c = trim_code(bytes, len);
        case (act)
            ACT_VERIFY_ADMIN: begin
                r.matched = !c.overlong && c.chars == pin_codes[0];
            end
            ACT_VERIFY_USER: begin
                if (!c.overlong) begin
                    foreach (pin_codes[i]) begin
                        if (pin_lens[i] >= 4'd4 && pin_codes[i] == c.chars) r.matched = 1'b1;
                    end
                end
            end
            ACT_STORE: begin
                if (slot >= TABLE_SLOTS_DEF) begin
                    r.status = 1'b1;
                end else begin
                    put_code(slot, c);
                    r = journal_page();
                end
            end
            ACT_INIT: begin
                clear_table();
                put_code(0, trim_code(admin_default, 4'd8));
                journal_seq = '0;
                r = journal_page();
            end
            ACT_RESTORE: begin
                if (slot >= TABLE_SLOTS_DEF) begin
                    r.status = 1'b1;
                end else begin
                    put_code(slot, c);
                    journal_seq = rseq;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [7:0] slot,
                             input logic [63:0] bytes, input logic [3:0] len,
                             input logic [31:0] rseq);
        while (gaps_on && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_user_slot <= slot;
        s_key_bytes <= bytes;
        s_key_length <= len;
        s_restore_sequence <= rseq;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(apply_pin_action(act, slot, bytes, len, rseq));
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    task automatic set_registers(input logic [63:0] key, input logic [31:0] base);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEFAULT_ADMIN_KEY;
        cfg_data <= key;
        do @(posedge aclk); while (!cfg_ready);
        admin_default = key;
        cfg_index <= CFG_REGION_BASE;
        cfg_data <= 64'(base);
        do @(posedge aclk); while (!cfg_ready);
        flash_base = base;
        cfg_valid <= 1'b0;
    endtask

    task automatic make_code(output logic [63:0] bytes, output logic [3:0] len);
        int n;
        n = $urandom_range(9);
        bytes = $urandom_range(1) ? {$urandom, $urandom} : 64'd0;
        for (int i = 0; i < 8; i++) begin
            if (i < n) bytes[8*i +: 8] = 8'h30 + 8'($urandom_range(9));
        end
        if ($urandom_range(19) == 0 && n > 1) bytes[8*$urandom_range(n - 1) +: 8] = 8'h00;
        len = (n == 9) ? 4'($urandom_range(15, 9)) : 4'(n);
    endtask

    // Presents a code already held in the table, sometimes disturbed so that it may miss.
    task automatic send_known_code(input logic [2:0] act, input int slot);
        logic [63:0] bytes;
        logic [3:0]  len;
        bytes = pin_codes[slot];
        len = pin_lens[slot];
        case ($urandom_range(3))
            0: begin
            end
            1: begin
                for (int i = 0; i < 8; i++) begin
                    if (i >= len) bytes[8*i +: 8] = 8'($urandom);
                end
            end
            2: len = 4'($urandom_range(15, len));
            default: begin
                len = 4'd8;
                bytes[$urandom_range(63)] = ~bytes[$urandom_range(63)];
            end
        endcase
        send_item(act, 8'($urandom), bytes, len, $urandom);
    endtask

    task automatic send_random_item();
        logic [63:0] bytes;
        logic [3:0]  len;
        logic [7:0]  slot;
        int          pick;
        pick = $urandom_range(99);
        make_code(bytes, len);
        slot = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        if (pick < 30) begin
            if ($urandom_range(4) == 0) send_item(ACT_VERIFY_USER, slot, bytes, len, $urandom);
            else send_known_code(ACT_VERIFY_USER, $urandom_range(15));
        end else if (pick < 45) begin
            if ($urandom_range(3) == 0) send_item(ACT_VERIFY_ADMIN, slot, bytes, len, $urandom);
            else send_known_code(ACT_VERIFY_ADMIN, 0);
        end else if (pick < 70) begin
            send_item(ACT_STORE, slot, bytes, len, $urandom);
        end else if (pick < 75) begin
            send_item(ACT_INIT, 8'($urandom), {$urandom, $urandom}, 4'($urandom), $urandom);
        end else if (pick < 80) begin
            send_item(ACT_RESTORE, slot, bytes, len,
                      $urandom_range(1) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom);
        end else if (pick < 85) begin
            send_item(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), 8'($urandom),
                      {$urandom, $urandom}, 4'($urandom), $urandom);
        end else begin
            send_item(3'($urandom), 8'($urandom), {$urandom, $urandom}, 4'($urandom), $urandom);
        end
    endtask

    task automatic test_directed_cases();
        send_item(ACT_VERIFY_ADMIN, 8'd0, 64'd0, 4'd0, 32'd0);
        send_item(ACT_VERIFY_USER, 8'd0, 64'd0, 4'd0, 32'd0);
        send_item(ACT_INIT, 8'hFF, {$urandom, $urandom}, 4'd15, 32'hFFFF_FFFF);
        send_item(ACT_VERIFY_ADMIN, 8'd0, pack_chars("12345678"), 4'd8, 32'd0);
        send_item(ACT_VERIFY_ADMIN, 8'd0, pack_chars("12345678"), 4'd9, 32'd0);
        send_item(ACT_VERIFY_USER, 8'd0, pack_chars("12345678"), 4'd15, 32'd0);
        send_item(ACT_VERIFY_USER, 8'd0, pack_chars("12345678"), 4'd8, 32'd0);
        send_item(ACT_STORE, 8'd15, pack_chars("9876") | 64'hA5A5_A5A5_0000_0000, 4'd4, 32'd0);
        send_item(ACT_VERIFY_USER, 8'd7, pack_chars("9876"), 4'd6, 32'd0);
        send_item(ACT_STORE, 8'd16, pack_chars("4444"), 4'd4, 32'd0);
        send_item(ACT_STORE, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFF);
        send_item(ACT_RESTORE, 8'd16, pack_chars("5555"), 4'd4, 32'd77);
        send_item(ACT_RESTORE, 8'd3, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hFFFF_FFFE);
        send_item(ACT_VERIFY_USER, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
        send_item(ACT_STORE, 8'd1, pack_chars("123"), 4'd3, 32'd0);
        send_item(ACT_VERIFY_USER, 8'd0, pack_chars("123"), 4'd3, 32'd0);
        send_item(ACT_STORE, 8'd2, 64'h3837_3635_3400_3231, 4'd8, 32'd0);
        send_item(ACT_STORE, 8'd15, 64'h1234_5678_9ABC_DEF0, 4'd0, 32'd0);
        send_item(ACT_VERIFY_USER, 8'd0, pack_chars("9876"), 4'd4, 32'd0);
        send_item(ACT_SPARE_LO, 8'd3, {$urandom, $urandom}, 4'd8, $urandom);
        send_item(ACT_SPARE_LO + 3'd1, 8'd20, {$urandom, $urandom}, 4'd4, $urandom);
        send_item(ACT_SPARE_HI, 8'd0, {$urandom, $urandom}, 4'd15, $urandom);
        send_item(ACT_VERIFY_ADMIN, 8'd0, pack_chars("12345678"), 4'd0, 32'd0);
        send_item(ACT_RESTORE, 8'd0, 64'd0, 4'd0, 32'd3);
        send_item(ACT_VERIFY_ADMIN, 8'd0, 64'h0000_0000_0000_00FF, 4'd0, 32'd0);
        drain_replies();
    endtask

    task automatic test_register_settings();
        logic [63:0] keys [5];
        logic [31:0] bases [5];
        keys = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h5758_595A_0043_4241,
                 {$urandom, $urandom}, DEFAULT_ADMIN_KEY_RESET};
        bases = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FF00, $urandom, REGION_BASE_RESET};
        for (int k = 0; k < 5; k++) begin
            set_registers(keys[k], bases[k]);
            send_item(ACT_INIT, 8'($urandom), {$urandom, $urandom}, 4'($urandom), $urandom);
            send_item(ACT_VERIFY_ADMIN, 8'd0, keys[k], 4'd8, 32'd0);
            repeat (50) send_random_item();
            drain_replies();
        end
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        hold_request = 400;
        repeat (30) send_random_item();
        drain_replies();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        for (int k = 0; k < 1100; k++) begin
            gaps_on = !(k >= 400 && k < 600);
            send_random_item();
        end
        gaps_on = 1'b1;
        drain_replies();
    endtask

    // The receiver honors a requested hold-off first, then stalls at random while gaps are on.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(gaps_on && $urandom_range(99) < 8);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin : reply_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $display("%0t: result transaction with no request outstanding", $time);
                mismatch_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("matched", 32'(want.matched), 32'(m_matched));
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("write_page", 32'(want.write_page), 32'(m_write_page));
                check_field("page_sequence", want.page_sequence, m_page_sequence);
                check_field("page_slot", 32'(want.page_slot), 32'(m_page_slot));
                check_field("page_address", want.page_address, m_page_address);
                check_field("erase_sector", 32'(want.erase_sector), 32'(m_erase_sector));
                check_field("page_checksum", want.page_checksum, m_page_checksum);
            end
        end
    end

    initial begin
        clear_table();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_register_settings();
        test_output_backpressure();
        test_random_traffic();
        drain_replies();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && replies_due.size() == 0) begin
            $display("** pin_table_with_journal_pages: PASSED **");
        end else begin
            $display("** pin_table_with_journal_pages: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** pin_table_with_journal_pages: FAILED **");
        $finish;
    end

endmodule
